// ===== src/euler_xyz_vector_rotator_macros.svh =====
// Assertion macros for the Euler XYZ vector rotator.
`ifndef EULER_XYZ_VECTOR_ROTATOR_MACROS_SVH
`define EULER_XYZ_VECTOR_ROTATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define EXR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define EXR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/exr_pkg.sv =====
// Shared constants and tables for the Euler XYZ vector rotator.
package exr_pkg;
  localparam int GuardBits   = 8;
  localparam int AngBits     = 16;
  localparam int ZBits       = 28;
  localparam int AtanEntries = 24;
  localparam int GainQ20     = 636751;
  localparam int Deg90       = 5760;
  localparam int Deg180      = 11520;
  localparam int Deg360      = 23040;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [ZBits-1:0] atan_lut(input logic [4:0] idx);
    logic [ZBits-1:0] r;
    case (idx)
      5'd0: r = 28'd2949120;  5'd1: r = 28'd1740967;  5'd2: r = 28'd919879;
      5'd3: r = 28'd466945;   5'd4: r = 28'd234379;   5'd5: r = 28'd117304;
      5'd6: r = 28'd58666;    5'd7: r = 28'd29335;    5'd8: r = 28'd14668;
      5'd9: r = 28'd7334;     5'd10: r = 28'd3667;    5'd11: r = 28'd1833;
      5'd12: r = 28'd917;     5'd13: r = 28'd458;     5'd14: r = 28'd229;
      5'd15: r = 28'd115;     5'd16: r = 28'd57;      5'd17: r = 28'd29;
      5'd18: r = 28'd14;      5'd19: r = 28'd7;       5'd20: r = 28'd4;
      5'd21: r = 28'd2;       5'd22: r = 28'd1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// ===== src/exr_cordic_cell.sv =====
// One CORDIC micro-rotation cell with a pipeline register.
module exr_cordic_cell #(
  parameter int W     = 26,
  parameter int Shift = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [W-1:0]           p_i,
  input  logic signed [W-1:0]           q_i,
  input  logic signed [exr_pkg::ZBits-1:0] z_i,
  output logic                          valid_o,
  output logic signed [W-1:0]           p_o,
  output logic signed [W-1:0]           q_o,
  output logic signed [exr_pkg::ZBits-1:0] z_o
);
  logic signed [W-1:0] p_d, q_d;
  logic signed [exr_pkg::ZBits-1:0] z_d, atan_c;
  logic valid_q;
  logic signed [W-1:0] p_q, q_q;
  logic signed [exr_pkg::ZBits-1:0] z_q;

  // micro-rotation, direction from residual angle sign
  always_comb begin
    atan_c = exr_pkg::atan_lut(5'(Shift));
    if (!z_i[exr_pkg::ZBits-1]) begin
      p_d = p_i - (q_i >>> Shift);
      q_d = q_i + (p_i >>> Shift);
      z_d = z_i - atan_c;
    end else begin
      p_d = p_i + (q_i >>> Shift);
      q_d = q_i - (p_i >>> Shift);
      z_d = z_i + atan_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      q_q <= q_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign p_o = p_q;
  assign q_o = q_q;
  assign z_o = z_q;
endmodule

// ===== src/exr_axis_rotator.sv =====
// One axis rotation: gain stage, combinational angle fold, and a row of CORDIC cells.
module exr_axis_rotator #(
  parameter int W     = 26,
  parameter int Steps = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [W-1:0]    a_i,
  input  logic signed [W-1:0]    b_i,
  input  logic signed [exr_pkg::AngBits-1:0] ang_i,
  output logic                   valid_o,
  output logic signed [W-1:0]    a_o,
  output logic signed [W-1:0]    b_o
);
  localparam int NSteps = (Steps < exr_pkg::AtanEntries) ? Steps : exr_pkg::AtanEntries;
  localparam int PW     = W + 21;

  // gain stage: scale both components, wrap angle
  logic signed [PW-1:0] pa, pb;
  logic signed [17:0] wa;
  logic signed [W-1:0] ga_q, gb_q;
  logic signed [17:0] gang_q;
  logic gv_q;

  always_comb begin
    pa = PW'(a_i) * PW'($signed(21'(exr_pkg::GainQ20)));
    pb = PW'(b_i) * PW'($signed(21'(exr_pkg::GainQ20)));
    wa = 18'(ang_i);
    if (wa >= 18'(exr_pkg::Deg180)) begin
      wa = wa - 18'(exr_pkg::Deg360);
    end else if (wa < -18'(exr_pkg::Deg180)) begin
      wa = wa + 18'(exr_pkg::Deg360);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
    end else if (en_i) begin
      gv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ga_q   <= W'(pa >>> 20);
      gb_q   <= W'(pb >>> 20);
      gang_q <= wa;
    end
  end

  // fold into [-90,90] degrees
  logic signed [W-1:0] fa, fb;
  logic signed [17:0] fang;
  logic flip;
  always_comb begin
    flip = 1'b0;
    fang = gang_q;
    if (gang_q > 18'sd5760) begin
      fang = gang_q - 18'(exr_pkg::Deg180);
      flip = 1'b1;
    end else if (gang_q < -18'sd5760) begin
      fang = gang_q + 18'(exr_pkg::Deg180);
      flip = 1'b1;
    end
    fa = flip ? -ga_q : ga_q;
    fb = flip ? -gb_q : gb_q;
  end

  logic                          cv [NSteps+1];
  logic signed [W-1:0]           cp [NSteps+1];
  logic signed [W-1:0]           cq [NSteps+1];
  logic signed [exr_pkg::ZBits-1:0] cz [NSteps+1];

  assign cv[0] = gv_q;
  assign cp[0] = fa;
  assign cq[0] = fb;
  assign cz[0] = exr_pkg::ZBits'(fang) <<< 10;

  for (genvar i = 0; i < NSteps; i++) begin : g_cell
    exr_cordic_cell #(.W(W), .Shift(i)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(cv[i]), .p_i(cp[i]), .q_i(cq[i]), .z_i(cz[i]),
      .valid_o(cv[i+1]), .p_o(cp[i+1]), .q_o(cq[i+1]), .z_o(cz[i+1])
    );
  end

  assign valid_o = cv[NSteps];
  assign a_o = cp[NSteps];
  assign b_o = cq[NSteps];
endmodule

// ===== src/euler_xyz_vector_rotator.sv =====
// Euler XYZ vector rotator: three pipelined CORDIC axis rotations.
// Throughput: one vector per cycle; the pipeline of CORDIC cells advances as one.
// The pipeline stalls as a whole when the output register holds a result not taken.
// Reset (rst_ni low, asynchronous) clears all valid flags; data registers are not reset.
module euler_xyz_vector_rotator #(
  parameter int CORDIC_STEPS   = 16,
  parameter int COMPONENT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // in_x, in_y, in_z, angle_about_x, angle_about_y, angle_about_z (low bit first)
  input  logic [3*COMPONENT_BITS+47:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_z (low bit first), zero pad
  output logic [((3*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic m_axis_tuser
);
  localparam int CB = COMPONENT_BITS;
  localparam int G  = exr_pkg::GuardBits;
  localparam int W  = CB + G + 3;
  localparam int OW = ((3*CB+7)/8)*8;

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [CB-1:0] ix, iy, iz;
  logic signed [15:0] ax, ay, az;
  assign ix = s_axis_tdata[CB-1:0];
  assign iy = s_axis_tdata[2*CB-1:CB];
  assign iz = s_axis_tdata[3*CB-1:2*CB];
  assign ax = s_axis_tdata[3*CB+15:3*CB];
  assign ay = s_axis_tdata[3*CB+31:3*CB+16];
  assign az = s_axis_tdata[3*CB+47:3*CB+32];

  // input register
  logic in_v_q;
  logic signed [W-1:0] x0_q, y0_q, z0_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= W'(ix) <<< G;
      y0_q <= W'(iy) <<< G;
      z0_q <= W'(iz) <<< G;
      ax_q <= ax;
      ay_q <= ay;
      az_q <= az;
    end
  end

  localparam int L = (CORDIC_STEPS < exr_pkg::AtanEntries ? CORDIC_STEPS
                      : exr_pkg::AtanEntries) + 1;

  // delay lines for the components and angles each axis does not touch
  logic signed [W-1:0] xd [L+1];
  logic signed [15:0] ayd [L+1];
  logic signed [15:0] azd [2*L+1];
  assign xd[0] = x0_q;
  assign ayd[0] = ay_q;
  assign azd[0] = az_q;
  for (genvar k = 0; k < 2*L; k++) begin : g_dz
    always_ff @(posedge clk_i) if (en) azd[k+1] <= azd[k];
  end
  for (genvar k = 0; k < L; k++) begin : g_dx
    always_ff @(posedge clk_i) begin
      if (en) begin
        xd[k+1]  <= xd[k];
        ayd[k+1] <= ayd[k];
      end
    end
  end

  logic v1, v2, v3;
  logic signed [W-1:0] y1, z1, z2, x2, x3, y3;
  exr_axis_rotator #(.W(W), .Steps(CORDIC_STEPS)) u_rx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_v_q), .a_i(y0_q), .b_i(z0_q),
    .ang_i(ax_q), .valid_o(v1), .a_o(y1), .b_o(z1));

  logic signed [W-1:0] y1d [L+1];
  assign y1d[0] = y1;
  for (genvar k = 0; k < L; k++) begin : g_dy
    always_ff @(posedge clk_i) if (en) y1d[k+1] <= y1d[k];
  end

  exr_axis_rotator #(.W(W), .Steps(CORDIC_STEPS)) u_ry (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .a_i(z1), .b_i(xd[L]),
    .ang_i(ayd[L]), .valid_o(v2), .a_o(z2), .b_o(x2));

  logic signed [W-1:0] z2d [L+1];
  assign z2d[0] = z2;
  for (genvar k = 0; k < L; k++) begin : g_dz2
    always_ff @(posedge clk_i) if (en) z2d[k+1] <= z2d[k];
  end

  exr_axis_rotator #(.W(W), .Steps(CORDIC_STEPS)) u_rz (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .a_i(x2), .b_i(y1d[L]),
    .ang_i(azd[2*L]), .valid_o(v3), .a_o(x3), .b_o(y3));

  // round, clamp
  localparam logic signed [W-1:0] Hi = W'((64'sd1 <<< (CB-1)) - 1);
  localparam logic signed [W-1:0] Lo = -Hi - W'(1);
  function automatic logic [CB:0] fin(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    logic s;
    r = (v + W'(1 <<< (G-1))) >>> G;
    s = 1'b0;
    if (r > Hi) begin
      r = Hi; s = 1'b1;
    end else if (r < Lo) begin
      r = Lo; s = 1'b1;
    end
    return {s, r[CB-1:0]};
  endfunction

  logic [CB:0] fx, fy, fz;
  assign fx = fin(x3);
  assign fy = fin(y3);
  assign fz = fin(z2d[L]);

  logic [OW-1:0] out_d_q;
  logic sat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v3;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q <= OW'({fz[CB-1:0], fy[CB-1:0], fx[CB-1:0]});
      sat_q   <= fx[CB] | fy[CB] | fz[CB];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = sat_q;

`include "euler_xyz_vector_rotator_macros.svh"
  `EXR_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `EXR_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `EXR_ASSERT_NEXT(a_stall_data, clk_i, rst_ni, !en, $stable(out_d_q) && $stable(sat_q))
endmodule

// ===== verif/euler_xyz_vector_rotator_tb.sv =====
// Testbench for the Euler XYZ vector rotator: directed corners and random streaming with a CORDIC predictor.
module euler_xyz_vector_rotator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps = 16;
  localparam int CompBits = 16;
  localparam int InW = 3 * CompBits + 48;
  localparam int OutW = ((3 * CompBits + 7) / 8) * 8;
  localparam int RandItems = 1530;

  typedef struct packed {
    logic [CompBits-1:0] x;
    logic [CompBits-1:0] y;
    logic [CompBits-1:0] z;
    logic sat;
  } rot_vec_t;

  // Expected rotated vectors, oldest first
  class rotation_scoreboard;
    rot_vec_t pending_q[$];
    int errors;
    int mismatches;

    // Counterclockwise rotation of the pair (a, b) by ang (1/64 degree)
    static function void cordic_pair(ref longint a, ref longint b, input longint ang);
      longint p, q, zr, ps, qs;
      p = (a * exr_pkg::GainQ20) >>> 20;
      q = (b * exr_pkg::GainQ20) >>> 20;
      while (ang >= exr_pkg::Deg180) ang -= exr_pkg::Deg360;
      while (ang < -exr_pkg::Deg180) ang += exr_pkg::Deg360;
      if (ang > exr_pkg::Deg90) begin
        ang -= exr_pkg::Deg180; p = -p; q = -q;
      end else if (ang < -exr_pkg::Deg90) begin
        ang += exr_pkg::Deg180; p = -p; q = -q;
      end
      zr = ang * 1024;
      for (int i = 0; i < Steps && i < exr_pkg::AtanEntries; i++) begin
        ps = p >>> i;
        qs = q >>> i;
        if (zr >= 0) begin
          p = p - qs; q = q + ps; zr -= longint'(exr_pkg::atan_lut(i[4:0]));
        end else begin
          p = p + qs; q = q - ps; zr += longint'(exr_pkg::atan_lut(i[4:0]));
        end
      end
      a = p;
      b = q;
    endfunction

    static function logic [CompBits-1:0] round_clamp(longint v, ref logic sat);
      longint hi, lo, r;
      hi = (longint'(1) <<< (CompBits - 1)) - 1;
      lo = -hi - 1;
      r = (v + (longint'(1) <<< (exr_pkg::GuardBits - 1))) >>> exr_pkg::GuardBits;
      if (r > hi) begin
        r = hi; sat = 1'b1;
      end else if (r < lo) begin
        r = lo; sat = 1'b1;
      end
      return r[CompBits-1:0];
    endfunction

    function void note_input(logic [InW-1:0] d);
      longint x, y, z, ax, ay, az;
      logic s;
      rot_vec_t e;
      x = longint'($signed(d[0 +: CompBits])) <<< exr_pkg::GuardBits;
      y = longint'($signed(d[CompBits +: CompBits])) <<< exr_pkg::GuardBits;
      z = longint'($signed(d[2*CompBits +: CompBits])) <<< exr_pkg::GuardBits;
      ax = longint'($signed(d[3*CompBits +: 16]));
      ay = longint'($signed(d[3*CompBits+16 +: 16]));
      az = longint'($signed(d[3*CompBits+32 +: 16]));
      cordic_pair(y, z, ax);
      cordic_pair(z, x, ay);
      cordic_pair(x, y, az);
      s = 1'b0;
      e.x = round_clamp(x, s);
      e.y = round_clamp(y, s);
      e.z = round_clamp(z, s);
      e.sat = s;
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [OutW-1:0] d, logic user);
      rot_vec_t e, a;
      a.x = d[0 +: CompBits];
      a.y = d[CompBits +: CompBits];
      a.z = d[2*CompBits +: CompBits];
      a.sat = user;
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected output transfer x=%h y=%h z=%h sat=%b", a.x, a.y, a.z, a.sat);
        return;
      end
      e = pending_q.pop_front();
      if (e !== a) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                   e.x, e.y, e.z, e.sat, a.x, a.y, a.z, a.sat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  bit stim_done = 1'b0;

  rotation_scoreboard sb = new();

  euler_xyz_vector_rotator #(.CORDIC_STEPS(Steps), .COMPONENT_BITS(CompBits)) u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Sample both sides at the edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver stall pattern: phases of always-ready, random, and mostly-stalled
  initial begin
    int phase;
    @(posedge rst_ni);
    forever begin
      phase = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        case (phase)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 32767) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'(($urandom_range(0, 8) - 4) * exr_pkg::Deg90);
    if (k == 2) return 16'(($urandom_range(0, 8) - 4) * exr_pkg::Deg90
                           + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(0, 2 * exr_pkg::Deg360) - exr_pkg::Deg360);
  endfunction

  // Present one vector and hold it until the transfer
  task automatic send_vec(logic [15:0] x, y, z, ax, ay, az);
    s_axis_tdata <= {az, ay, ax, z, y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stimulus: directed corners, then bursts of random vectors
  initial begin
    int left, burst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_vec(16'h4000, 16'h0000, 16'h0000, 16'd0, 16'd0, 16'd0);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd0, 16'd0);
    send_vec(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0);
    send_vec(16'h4000, 16'h2000, 16'h1000, 16'(exr_pkg::Deg90), 16'(exr_pkg::Deg90),
             16'(exr_pkg::Deg90));
    send_vec(16'h4000, 16'h2000, 16'h1000, 16'(-exr_pkg::Deg90), 16'(-exr_pkg::Deg90),
             16'(-exr_pkg::Deg90));
    send_vec(16'h4000, 16'h2000, 16'h1000, 16'(exr_pkg::Deg90 + 1),
             16'(-exr_pkg::Deg90 - 1), 16'(exr_pkg::Deg180));
    send_vec(16'h4000, 16'h2000, 16'h1000, 16'(-exr_pkg::Deg180),
             16'(exr_pkg::Deg180 - 1), 16'(exr_pkg::Deg360));
    send_vec(16'h4000, 16'h2000, 16'h1000, 16'(-exr_pkg::Deg360), 16'h7fff, 16'h8000);
    send_vec(16'h7fff, 16'h8000, 16'h7fff, 16'd2880, 16'd2880, 16'd2880);
    send_vec(16'h8000, 16'h7fff, 16'h8000, 16'(-2880), 16'd2880, 16'(-2880));
    send_vec(16'h7fff, 16'h7fff, 16'h0000, 16'd0, 16'd0, 16'd2880);
    send_vec(16'h0001, 16'hffff, 16'h0000, 16'd1, 16'hffff, 16'd64);
    send_vec(16'h5555, 16'haaaa, 16'h3333, 16'h5555, 16'haaaa, 16'hffff);
    left = RandItems;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_vec(rand_comp(), rand_comp(), rand_comp(),
                              rand_angle(), rand_angle(), rand_angle());
      left -= burst;
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Drain and verdict
  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (3 * (Steps + 2) + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/exr_pkg.sv
src/exr_cordic_cell.sv
src/exr_axis_rotator.sv
src/euler_xyz_vector_rotator.sv
verif/euler_xyz_vector_rotator_tb.sv
